>>> rtl/core/sync_frame_deframer_crc16_core_defines.svh
// Assertion macros used by the deframer datapath, sfdcrc_dp.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SYNC_FRAME_DEFRAMER_CRC16_CORE_DEFINES_SVH
`define SYNC_FRAME_DEFRAMER_CRC16_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFDCRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFDCRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sfdcrc_pkg.sv
// Package for the deframer: constants, the controller/datapath interface
// structs and the CRC-16 byte update. Depends on nothing.
package sfdcrc_pkg;

  localparam int          MAX_WORDS_DEFAULT = 16;
  localparam int          CFG_W             = 5;
  localparam logic [4:0]  WORDS_RESET       = 5'd14;
  localparam logic [7:0]  HDR_GT            = 8'h3E;
  localparam logic [7:0]  HDR_STAR          = 8'h2A;
  localparam logic [15:0] CRC_INIT          = 16'h00FF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_tag;
    logic take_data;
    logic take_crclo;
    logic start_emit;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_gt;
    logic is_star;
    logic data_last;
    logic crc_match;
    logic emit_last;
    logic out_free;
  } sts_t;

  // Reflected CCITT update, one byte.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
  endfunction

endpackage

>>> rtl/core/sfdcrc_dp.sv
// Datapath of the deframer: config register, CRC, payload memory and output register.
// Depends on sfdcrc_pkg and the assertion macros header.
`include "sync_frame_deframer_crc16_core_defines.svh"

module sfdcrc_dp #(
  parameter int MAX_WORDS = sfdcrc_pkg::MAX_WORDS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    rx_byte,
  input  logic                          cfg_we,
  input  logic [sfdcrc_pkg::CFG_W-1:0]  cfg_words,
  input  sfdcrc_pkg::cmd_t              cmd_i,
  output sfdcrc_pkg::sts_t              sts_o,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [15:0]            out_word_value,
  output logic [3:0]                    out_word_index,
  output logic [7:0]                    out_frame_tag,
  output logic                          out_last_word
);

  localparam int KW  = $clog2(MAX_WORDS + 1);
  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int BCW = KW + 1;

  logic [sfdcrc_pkg::CFG_W-1:0] words_r;
  logic [KW-1:0]  nwords_r, eff_words, k_r;
  logic [BCW-1:0] bcnt_r;
  logic [15:0]    crc_r;
  logic [7:0]     tag_r, crc_lo_r, lo_byte_r;
  logic [15:0]    mem [MAX_WORDS];
  logic [15:0]    rdata_r;
  logic           out_valid_r;
  logic [15:0]    out_word_r;
  logic [3:0]     out_idx_r;
  logic [7:0]     out_tag_r;
  logic           out_last_r;

  // Saturate the programmed word count to 1..MAX_WORDS.
  always_comb begin
    if (words_r == '0) begin
      eff_words = KW'(1);
    end else if (int'(words_r) > MAX_WORDS) begin
      eff_words = KW'(MAX_WORDS);
    end else begin
      eff_words = KW'(words_r);
    end
  end

  assign sts_o.is_gt     = (rx_byte == sfdcrc_pkg::HDR_GT);
  assign sts_o.is_star   = (rx_byte == sfdcrc_pkg::HDR_STAR);
  assign sts_o.data_last = ((bcnt_r + BCW'(1)) == {nwords_r, 1'b0});
  assign sts_o.crc_match = ({rx_byte, crc_lo_r} == crc_r);
  assign sts_o.emit_last = (({1'b0, k_r} + BCW'(1)) == {1'b0, nwords_r});
  assign sts_o.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r     <= sfdcrc_pkg::WORDS_RESET;
      nwords_r    <= KW'(1);
      bcnt_r      <= '0;
      crc_r       <= sfdcrc_pkg::CRC_INIT;
      tag_r       <= '0;
      crc_lo_r    <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        words_r <= cfg_words;
      end
      if (cmd_i.latch_tag) begin
        tag_r    <= rx_byte;
        nwords_r <= eff_words;
        bcnt_r   <= '0;
        crc_r    <= sfdcrc_pkg::CRC_INIT;
      end
      if (cmd_i.take_data) begin
        crc_r  <= sfdcrc_pkg::crc_step(crc_r, rx_byte);
        bcnt_r <= bcnt_r + BCW'(1);
      end
      if (cmd_i.take_crclo) begin
        crc_lo_r <= rx_byte;
      end
      if (cmd_i.start_emit) begin
        k_r <= '0;
      end else if (cmd_i.load_out) begin
        k_r <= k_r + KW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload memory: one word written per odd byte, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd_i.take_data) begin
      if (bcnt_r[0]) begin
        mem[bcnt_r[AW:1]] <= {rx_byte, lo_byte_r};
      end else begin
        lo_byte_r <= rx_byte;
      end
    end
    rdata_r <= mem[k_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_word_r <= rdata_r;
      out_idx_r  <= 4'(k_r);
      out_tag_r  <= tag_r;
      out_last_r <= sts_o.emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word_value = $signed(out_word_r);
  assign out_word_index = out_idx_r;
  assign out_frame_tag  = out_tag_r;
  assign out_last_word  = out_last_r;

  `SFDCRC_ASSERT_IMP(a_load_free, cmd_i.load_out, sts_o.out_free, "output overwritten")
  `SFDCRC_ASSERT_IMP(a_data_range, cmd_i.take_data, bcnt_r < (BCW'(nwords_r) << 1), "payload overrun")
  `SFDCRC_ASSERT_NXT(a_load_valid, cmd_i.load_out, out_valid_r, "loaded word not presented")

endmodule

>>> rtl/core/sfdcrc_ctrl.sv
// Controller of the deframer: header hunt, frame sequencing and word emission.
// Depends on sfdcrc_pkg.
module sfdcrc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sfdcrc_pkg::sts_t sts_i,
  output sfdcrc_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_HUNT  = 9'b000000001,
    ST_STAR  = 9'b000000010,
    ST_GT2   = 9'b000000100,
    ST_TAG   = 9'b000001000,
    ST_DATA  = 9'b000010000,
    ST_CRCLO = 9'b000100000,
    ST_CRCHI = 9'b001000000,
    ST_FETCH = 9'b010000000,
    ST_LOAD  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  // Bytes are refused only while words are read out of the payload memory.
  assign in_stall = (state_r == ST_FETCH) || (state_r == ST_LOAD);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_HUNT: begin
        if (acc && sts_i.is_gt) state_nxt = ST_STAR;
      end
      ST_STAR: begin
        if (acc) begin
          if (sts_i.is_star) state_nxt = ST_GT2;
          else if (sts_i.is_gt) state_nxt = ST_STAR;
          else state_nxt = ST_HUNT;
        end
      end
      ST_GT2: begin
        if (acc) state_nxt = sts_i.is_gt ? ST_TAG : ST_HUNT;
      end
      ST_TAG: begin
        if (acc) begin
          cmd_o.latch_tag = 1'b1;
          state_nxt       = ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd_o.take_data = 1'b1;
          if (sts_i.data_last) state_nxt = ST_CRCLO;
        end
      end
      ST_CRCLO: begin
        if (acc) begin
          cmd_o.take_crclo = 1'b1;
          state_nxt        = ST_CRCHI;
        end
      end
      ST_CRCHI: begin
        if (acc) begin
          if (sts_i.crc_match) begin
            cmd_o.start_emit = 1'b1;
            state_nxt        = ST_FETCH;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = sts_i.emit_last ? ST_HUNT : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/sync_frame_deframer_crc16_core.sv
// Top level of the serial frame deframer with CRC-16 check.
// Instantiates sfdcrc_ctrl and sfdcrc_dp; depends on sfdcrc_pkg.
//
// Usage:
// The input channel (in_valid, in_stall, in_rx_byte) carries one received serial
// byte per transfer. The block hunts for the header '>' '*' '>', takes one tag
// byte, 2*N payload bytes and two CRC bytes (low byte first). N is the word
// count programmed through cfg_we/cfg_words_in_use, clamped to 1..MAX_WORDS and
// sampled when the tag byte arrives; write it only while the block is idle.
// While a frame is received, the input is never stalled.
// When the CRC (initial value 0x00FF, over the payload only) matches, the
// block emits N result transfers on the output channel, one signed 16-bit
// little-endian word each, with its index, the frame tag and a last flag.
// Each word is first read from the payload memory into a register (FETCH)
// and then loaded into the output register (LOAD), once that register is
// free. The input is stalled during emission; a frame is 2*N+6 bytes long.
// A bad frame emits nothing and hunting resumes with the next byte.
// If the receiver stalls, the word in the output register holds and readout
// pauses; after the last word is loaded, new bytes are taken while it waits.
// Reset (rst_n low, synchronous) returns to hunting, sets N to 14 and empties
// the output register.
module sync_frame_deframer_crc16_core #(
  parameter int MAX_WORDS = sfdcrc_pkg::MAX_WORDS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_word_value,
  output logic [3:0]                    out_word_index,
  output logic [7:0]                    out_frame_tag,
  output logic                          out_last_word,
  input  logic                          cfg_we,
  input  logic [sfdcrc_pkg::CFG_W-1:0]  cfg_words_in_use
);

  // Commands and status are the only connection between the two halves.
  sfdcrc_pkg::cmd_t cmd;
  sfdcrc_pkg::sts_t sts;

  sfdcrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  sfdcrc_dp #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_byte        (in_rx_byte),
    .cfg_we         (cfg_we),
    .cfg_words      (cfg_words_in_use),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_word_value (out_word_value),
    .out_word_index (out_word_index),
    .out_frame_tag  (out_frame_tag),
    .out_last_word  (out_last_word)
  );

endmodule
